// File: design/fern_ifs_point_generator_core_macros.svh
// Assertion macros for the fern point generator. Each macro checks on the rising edge of
// clock and is disabled while reset is high.
`ifndef FERN_IFS_POINT_GENERATOR_CORE_MACROS_SVH
`define FERN_IFS_POINT_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define FERN_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("fern_ifs: invariant violated");

`define FERN_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("fern_ifs: implication violated");

`define FERN_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("fern_ifs: next-cycle check violated");

`else

`define FERN_ASSERT_ALWAYS(label, cond)
`define FERN_ASSERT_IMPLY(label, pre, post)
`define FERN_ASSERT_NEXT(label, pre, post)

`endif

`endif

// File: design/fern_ifs_pkg.sv
`timescale 1ns / 1ps

package fern_ifs_pkg;

   typedef enum logic [1:0] {
      MAP_MAIN  = 2'd0,
      MAP_LEFT  = 2'd1,
      MAP_RIGHT = 2'd2,
      MAP_STEM  = 2'd3
   } map_type;

   typedef enum logic [2:0] {
      CSR_THRESHOLD_FIRST  = 3'd0,
      CSR_THRESHOLD_SECOND = 3'd1,
      CSR_THRESHOLD_THIRD  = 3'd2,
      CSR_START_X          = 3'd3,
      CSR_START_Y          = 3'd4
   } csr_index_type;

   localparam int COORD_W = 16;
   localparam int COEF_W  = 13;
   localparam int FRAC_SHIFT = 12;

   localparam logic [15:0] THRESHOLD_FIRST_RESET  = 16'd55706;
   localparam logic [15:0] THRESHOLD_SECOND_RESET = 16'd60293;
   localparam logic [15:0] THRESHOLD_THIRD_RESET  = 16'd63570;

   // Coefficients are Q.12 and offsets are Q4.11.
   localparam logic signed [COEF_W-1:0] COEF_085 = 13'sd3482;
   localparam logic signed [COEF_W-1:0] COEF_004 = 13'sd164;
   localparam logic signed [COEF_W-1:0] COEF_020 = 13'sd819;
   localparam logic signed [COEF_W-1:0] COEF_026 = 13'sd1065;
   localparam logic signed [COEF_W-1:0] COEF_023 = 13'sd942;
   localparam logic signed [COEF_W-1:0] COEF_022 = 13'sd901;
   localparam logic signed [COEF_W-1:0] COEF_015 = 13'sd614;
   localparam logic signed [COEF_W-1:0] COEF_028 = 13'sd1147;
   localparam logic signed [COEF_W-1:0] COEF_024 = 13'sd983;
   localparam logic signed [COEF_W-1:0] COEF_ZERO = 13'sd0;
   localparam logic signed [COORD_W-1:0] OFFS_160 = 16'sd3277;
   localparam logic signed [COORD_W-1:0] OFFS_044 = 16'sd901;
   localparam logic signed [COORD_W-1:0] OFFS_ZERO = 16'sd0;

   typedef struct packed {
      logic signed [COEF_W-1:0]  cxx;
      logic signed [COEF_W-1:0]  cxy;
      logic signed [COEF_W-1:0]  cyx;
      logic signed [COEF_W-1:0]  cyy;
      logic signed [COORD_W-1:0] offset_y;
   } coef_set_type;

   function automatic coef_set_type map_coefs(input map_type map_sel);
      coef_set_type c;
      case (map_sel)
         MAP_MAIN: begin
            c = '{cxx: COEF_085, cxy: COEF_ZERO, cyx: -COEF_004, cyy: COEF_085,
                  offset_y: OFFS_160};
         end
         MAP_LEFT: begin
            c = '{cxx: COEF_020, cxy: -COEF_026, cyx: COEF_023, cyy: COEF_022,
                  offset_y: OFFS_160};
         end
         MAP_RIGHT: begin
            c = '{cxx: -COEF_015, cxy: COEF_028, cyx: COEF_026, cyy: COEF_024,
                  offset_y: OFFS_044};
         end
         default: begin
            c = '{cxx: COEF_ZERO, cxy: COEF_ZERO, cyx: COEF_ZERO, cyy: COEF_026,
                  offset_y: OFFS_ZERO};
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [18:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 19'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -19'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: design/fern_ifs_affine.sv
`timescale 1ns / 1ps

module fern_ifs_affine import fern_ifs_pkg::*; (
   input  map_type                   map_sel,
   input  logic signed [COORD_W-1:0] x,
   input  logic signed [COORD_W-1:0] y,
   output logic signed [COORD_W-1:0] new_x,
   output logic signed [COORD_W-1:0] new_y
);

   coef_set_type       coefs;
   logic signed [28:0] prod_xx;
   logic signed [28:0] prod_xy;
   logic signed [28:0] prod_yx;
   logic signed [28:0] prod_yy;
   logic signed [29:0] sum_x;
   logic signed [29:0] sum_y;
   logic signed [18:0] pre_x;
   logic signed [18:0] pre_y;

   assign coefs = map_coefs(map_sel);

   assign prod_xx = x * coefs.cxx;
   assign prod_xy = y * coefs.cxy;
   assign prod_yx = x * coefs.cyx;
   assign prod_yy = y * coefs.cyy;

   assign sum_x = {prod_xx[28], prod_xx} + {prod_xy[28], prod_xy};
   assign sum_y = {prod_yx[28], prod_yx} + {prod_yy[28], prod_yy};

   // Dropping the low twelve bits of a two's complement value rounds toward minus infinity.
   assign pre_x = {sum_x[29], sum_x[29:FRAC_SHIFT]};
   assign pre_y = {sum_y[29], sum_y[29:FRAC_SHIFT]}
                + {{3{coefs.offset_y[COORD_W-1]}}, coefs.offset_y};

   assign new_x = sat_coord(pre_x);
   assign new_y = sat_coord(pre_y);

endmodule

// File: design/fern_ifs_point_generator_core.sv
`timescale 1ns / 1ps

// Fern attractor point generator. Each request transaction carries a 16-bit random value
// and a restart flag; the random value is compared against three thresholds to choose one
// of four affine maps, which is applied to the stored point (or to the start point when
// restart is set). The response transaction returns the new point in signed Q4.11 and the
// map index. The block takes one transaction per clock unless rsp_stall holds a response:
// map selection happens in the input register stage, and the multiply-add and saturation
// run between that stage and the result register, which also updates the stored point.
// Configuration registers are written through the csr port, which is always ready.

module fern_ifs_point_generator_core import fern_ifs_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [15:0]               req_random_value,
   input  logic                      req_restart,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic [1:0]                rsp_map_used,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [15:0]               csr_wdata
);

   logic [15:0]               threshold_first_ff, threshold_first_in;
   logic [15:0]               threshold_second_ff, threshold_second_in;
   logic [15:0]               threshold_third_ff, threshold_third_in;
   logic signed [COORD_W-1:0] start_x_ff, start_x_in;
   logic signed [COORD_W-1:0] start_y_ff, start_y_in;

   logic                      in_valid_ff, in_valid_in;
   map_type                   in_map_ff, in_map_in;
   logic                      in_restart_ff, in_restart_in;

   logic                      out_valid_ff, out_valid_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in;
   logic signed [COORD_W-1:0] out_y_ff, out_y_in;
   map_type                   out_map_ff, out_map_in;

   logic signed [COORD_W-1:0] point_x_ff, point_x_in;
   logic signed [COORD_W-1:0] point_y_ff, point_y_in;

   logic                      req_accept;
   logic                      out_ready;
   logic                      fire;
   map_type                   sel_map;
   logic signed [COORD_W-1:0] cur_x;
   logic signed [COORD_W-1:0] cur_y;
   logic signed [COORD_W-1:0] next_x;
   logic signed [COORD_W-1:0] next_y;

   assign csr_ready = 1'b1;

   always_comb begin
      threshold_first_in  = threshold_first_ff;
      threshold_second_in = threshold_second_ff;
      threshold_third_in  = threshold_third_ff;
      start_x_in          = start_x_ff;
      start_y_in          = start_y_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD_FIRST:  threshold_first_in  = csr_wdata;
            CSR_THRESHOLD_SECOND: threshold_second_in = csr_wdata;
            CSR_THRESHOLD_THIRD:  threshold_third_in  = csr_wdata;
            CSR_START_X:          start_x_in          = csr_wdata;
            CSR_START_Y:          start_y_in          = csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_ready  = !out_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_ready;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_random_value < threshold_first_ff) begin
         sel_map = MAP_MAIN;
      end else if (req_random_value < threshold_second_ff) begin
         sel_map = MAP_LEFT;
      end else if (req_random_value < threshold_third_ff) begin
         sel_map = MAP_RIGHT;
      end else begin
         sel_map = MAP_STEM;
      end
   end

   always_comb begin
      in_map_in     = in_map_ff;
      in_restart_in = in_restart_ff;
      if (req_accept) begin
         in_valid_in   = 1'b1;
         in_map_in     = sel_map;
         in_restart_in = req_restart;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   assign cur_x = in_restart_ff ? start_x_ff : point_x_ff;
   assign cur_y = in_restart_ff ? start_y_ff : point_y_ff;

   fern_ifs_affine u_affine (
      .map_sel (in_map_ff),
      .x       (cur_x),
      .y       (cur_y),
      .new_x   (next_x),
      .new_y   (next_y)
   );

   always_comb begin
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_map_in = out_map_ff;
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_x_in     = next_x;
         out_y_in     = next_y;
         out_map_in   = in_map_ff;
         point_x_in   = next_x;
         point_y_in   = next_y;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_first_ff  <= THRESHOLD_FIRST_RESET;
         threshold_second_ff <= THRESHOLD_SECOND_RESET;
         threshold_third_ff  <= THRESHOLD_THIRD_RESET;
         start_x_ff          <= '0;
         start_y_ff          <= '0;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         point_x_ff          <= '0;
         point_y_ff          <= '0;
      end else begin
         threshold_first_ff  <= threshold_first_in;
         threshold_second_ff <= threshold_second_in;
         threshold_third_ff  <= threshold_third_in;
         start_x_ff          <= start_x_in;
         start_y_ff          <= start_y_in;
         in_valid_ff         <= in_valid_in;
         out_valid_ff        <= out_valid_in;
         point_x_ff          <= point_x_in;
         point_y_ff          <= point_y_in;
      end
   end

   always_ff @(posedge clock) begin
      in_map_ff     <= in_map_in;
      in_restart_ff <= in_restart_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_map_ff    <= out_map_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_x    = out_x_ff;
   assign rsp_out_y    = out_y_ff;
   assign rsp_map_used = out_map_ff;

`include "fern_ifs_point_generator_core_macros.svh"

   `FERN_ASSERT_IMPLY(a_stem_zero_x, rsp_valid && (out_map_ff == MAP_STEM), rsp_out_x == '0)
   `FERN_ASSERT_IMPLY(a_point_is_rsp, rsp_valid, {point_x_ff, point_y_ff} == {out_x_ff, out_y_ff})
   `FERN_ASSERT_NEXT(a_pending_item_kept, in_valid_ff && !fire, in_valid_ff)
   `FERN_ASSERT_ALWAYS(a_no_accept_when_blocked, !(req_accept && in_valid_ff && !fire))

endmodule
